>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file sbrq_chk.sv.
// No dependencies; every use needs clk_i in scope, and SBRQ_ASSERT also needs rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define SBRQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sbrq assertion failed");

// Clocked assertion that also holds during reset.
`define SBRQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sbrq assertion failed");

`endif

>>> hw/rtl/sbrq_pkg.sv
// Package for the sporadic budget refill queue: payload types, config codes, reset values.
// No dependencies.
`timescale 1ns / 1ps

package sbrq_pkg;

  localparam int unsigned DataW          = 64;
  localparam int unsigned CountW         = 5;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned DefMaxRefills  = 16;
  localparam int unsigned DivSteps       = DataW;

  localparam logic [DataW-1:0]  RstPeriod    = 64'd10000;
  localparam logic [DataW-1:0]  RstMinBudget = 64'd2;
  localparam logic [CountW-1:0] RstLimit     = 5'd16;
  localparam logic [DataW-1:0]  RstWcet      = 64'd0;
  localparam logic [DataW-1:0]  RstInitBudget = 64'd10000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD       = 3'd0,
    CFG_MIN_BUDGET   = 3'd1,
    CFG_REFILL_LIMIT = 3'd2,
    CFG_KERNEL_WCET  = 3'd3,
    CFG_INIT_BUDGET  = 3'd4
  } sbrq_cfg_e;

  typedef struct packed {
    logic [DataW-1:0] usage;
    logic [DataW-1:0] capacity;
    logic [DataW-1:0] now;
  } sbrq_in_t;

  typedef struct packed {
    logic [DataW-1:0]  head_amount;
    logic [DataW-1:0]  head_time;
    logic [CountW-1:0] refill_count;
    logic              head_ready;
  } sbrq_out_t;

  typedef struct packed {
    logic [DataW-1:0] tim;
    logic [DataW-1:0] amt;
  } sbrq_word_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] acc;
  } sbrq_div_res_t;

endpackage

>>> hw/rtl/sporadic_budget_refill_queue.sv
// Sporadic budget refill queue. Each input beat charges usage against a circular
// queue of refills and yields one result beat with the head refill, queue size and
// readiness. All refill slots sit in one synchronous RAM; a sequencer reads, updates
// and writes back one slot per step. With nonzero capacity an item may split the
// head refill, the remainder merging into the next refill where needed, and final
// folding merges head refills into the next while they fall below the minimum
// budget or the queue is full. Zero capacity first pops and reschedules refills
// (at most 2 * MAX_REFILLS), divides a lone nonzero refill with the bit-serial
// divider, applies an overrun delay and checks the head against the next refill,
// then goes on as above. After reset and after a write of refill_limit or
// initial_budget, slot 0 is reloaded before the next item is taken. Result beats
// sit in an output register, so a stalled consumer only holds the final step.
`timescale 1ns / 1ps

module sporadic_budget_refill_queue
  import sbrq_pkg::*;
#(
  parameter int unsigned MAX_REFILLS = DefMaxRefills
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sbrq_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sbrq_out_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  localparam int unsigned IW  = (MAX_REFILLS > 1) ? $clog2(MAX_REFILLS) : 1;
  localparam int unsigned LW  = IW + 1;
  localparam int unsigned Exh = 2 * MAX_REFILLS;
  localparam int unsigned SW  = $clog2(Exh + 1);
  localparam int unsigned LimRst = (int'(RstLimit) > MAX_REFILLS) ? MAX_REFILLS
                                                                  : int'(RstLimit);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_EX_RD  = 20'h00002,
    S_EX_CHK = 20'h00004,
    S_EX_DIV = 20'h00008,
    S_OV_RD  = 20'h00010,
    S_OV_UPD = 20'h00020,
    S_OV_NRD = 20'h00040,
    S_OV_MRG = 20'h00080,
    S_SP_RD  = 20'h00100,
    S_SP_CHK = 20'h00200,
    S_SP_MRD = 20'h00400,
    S_SP_MWR = 20'h00800,
    S_PU_RD  = 20'h01000,
    S_PU_WR  = 20'h02000,
    S_FD_RD  = 20'h04000,
    S_FD_CHK = 20'h08000,
    S_FD_MRD = 20'h10000,
    S_FD_MWR = 20'h20000,
    S_OUT_RD = 20'h40000,
    S_OUT_WR = 20'h80000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic [IW-1:0]    hd_q, hd_d, tl_q, tl_d;
  logic [DataW-1:0] usage_q, usage_d, thr_q, thr_d;
  logic [DataW-1:0] pa_q, pa_d, pt_q, pt_d, ha_q, ha_d, ht_q, ht_d;
  logic [SW-1:0]    steps_q, steps_d;
  sbrq_out_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             reload_q, reload_d;

  logic [DataW-1:0] period_q, min_q, wcet_q, init_q;
  logic [LW-1:0]    lim_q;
  logic [CountW-1:0] lim_raw;

  logic             we;
  logic [IW-1:0]    waddr, raddr;
  sbrq_word_t       wdata, rd;
  logic             div_start;
  sbrq_div_res_t    div_res;

  logic [LW-1:0]    qsize;
  logic             qfull, single;
  logic [IW-1:0]    hd_nxt, tl_nxt;
  logic [DataW-1:0] rem_amt, sum_ht;

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i, input logic [LW-1:0] l);
    logic [LW-1:0] s;
    s = {1'b0, i} + 1'b1;
    return (s >= l) ? '0 : s[IW-1:0];
  endfunction

  assign hd_nxt = nxt(hd_q, lim_q);
  assign tl_nxt = nxt(tl_q, lim_q);
  assign single = (hd_q == tl_q);
  assign qsize  = (hd_q <= tl_q) ? ({1'b0, tl_q} - {1'b0, hd_q} + 1'b1)
                                 : ({1'b0, tl_q} + 1'b1 + lim_q - {1'b0, hd_q});
  assign qfull  = (qsize == lim_q);
  assign rem_amt = rd.amt - usage_q;
  assign sum_ht  = ht_q + ha_q;

  assign in_ready_o  = (state_q == S_IDLE) && !reload_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  sbrq_mem #(
    .Depth (MAX_REFILLS),
    .AddrW (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  sbrq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (usage_q),
    .divisor_i  (rd.amt),
    .period_i   (period_q),
    .res_o      (div_res)
  );

  always_comb begin
    unique case (state_q)
      S_OV_NRD: raddr = hd_nxt;
      S_PU_RD:  raddr = tl_q;
      default:  raddr = hd_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    hd_d        = hd_q;
    tl_d        = tl_q;
    usage_d     = usage_q;
    thr_d       = thr_q;
    pa_d        = pa_q;
    pt_d        = pt_q;
    ha_d        = ha_q;
    ht_d        = ht_q;
    steps_d     = steps_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    reload_d    = reload_q;
    we          = 1'b0;
    waddr       = hd_q;
    wdata       = '{tim: rd.tim, amt: rd.amt};
    div_start   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (reload_q) begin
          we       = 1'b1;
          waddr    = '0;
          wdata    = '{tim: '0, amt: init_q};
          hd_d     = '0;
          tl_d     = '0;
          reload_d = 1'b0;
        end else if (in_valid_i) begin
          usage_d = in_data_i.usage;
          thr_d   = in_data_i.now + wcet_q;
          steps_d = '0;
          state_d = (in_data_i.capacity == '0) ? S_EX_RD : S_SP_RD;
        end
      end
      S_EX_RD: state_d = S_EX_CHK;
      S_EX_CHK: begin
        if (rd.amt > usage_q) begin
          state_d = S_OV_RD;
        end else if (single) begin
          if (rd.amt == '0) begin
            we      = 1'b1;
            wdata   = '{tim: rd.tim + period_q, amt: rd.amt};
            state_d = S_OV_RD;
          end else begin
            ha_d      = rd.amt;
            ht_d      = rd.tim;
            div_start = 1'b1;
            state_d   = S_EX_DIV;
          end
        end else if (steps_q >= SW'(Exh)) begin
          state_d = S_OV_RD;
        end else begin
          steps_d = steps_q + 1'b1;
          usage_d = usage_q - rd.amt;
          pa_d    = rd.amt;
          pt_d    = rd.tim + period_q;
          hd_d    = hd_nxt;
          ret_d   = S_EX_RD;
          state_d = S_PU_RD;
        end
      end
      S_EX_DIV: begin
        if (div_res.done) begin
          we      = 1'b1;
          wdata   = '{tim: ht_q + div_res.acc, amt: ha_q};
          usage_d = div_res.rem;
          state_d = S_OV_RD;
        end
      end
      S_OV_RD: state_d = (usage_q == '0) ? S_SP_RD : S_OV_UPD;
      S_OV_UPD: begin
        we      = 1'b1;
        wdata   = '{tim: rd.tim + usage_q, amt: rd.amt};
        ht_d    = rd.tim + usage_q;
        ha_d    = rd.amt;
        state_d = single ? S_SP_RD : S_OV_NRD;
      end
      S_OV_NRD: state_d = S_OV_MRG;
      S_OV_MRG: begin
        if (sum_ht >= rd.tim) begin
          hd_d  = hd_nxt;
          we    = 1'b1;
          waddr = hd_nxt;
          wdata = '{tim: ht_q, amt: rd.amt + ha_q};
        end
        state_d = S_SP_RD;
      end
      S_SP_RD: state_d = S_SP_CHK;
      S_SP_CHK: begin
        state_d = S_FD_RD;
        if (rd.amt > usage_q && rd.tim <= thr_q) begin
          pa_d = usage_q;
          pt_d = rd.tim + period_q;
          if (qfull || rem_amt < min_q) begin
            if (single) begin
              we    = 1'b1;
              wdata = '{tim: rd.tim + period_q, amt: rd.amt};
            end else begin
              hd_d    = hd_nxt;
              ha_d    = rem_amt;
              state_d = S_SP_MRD;
            end
          end else begin
            we      = 1'b1;
            wdata   = '{tim: rd.tim + usage_q, amt: rem_amt};
            ret_d   = S_FD_RD;
            state_d = S_PU_RD;
          end
        end
      end
      S_SP_MRD: state_d = S_SP_MWR;
      S_SP_MWR: begin
        we      = 1'b1;
        wdata   = '{tim: rd.tim, amt: rd.amt + ha_q};
        ret_d   = S_FD_RD;
        state_d = S_PU_RD;
      end
      S_PU_RD: state_d = S_PU_WR;
      S_PU_WR: begin
        we      = 1'b1;
        waddr   = tl_q;
        if (pa_q < min_q && !single) begin
          wdata = '{tim: (pt_q > rd.tim) ? pt_q : rd.tim, amt: rd.amt + pa_q};
        end else if (pt_q <= rd.tim) begin
          wdata = '{tim: rd.tim, amt: rd.amt + pa_q};
        end else begin
          tl_d  = tl_nxt;
          waddr = tl_nxt;
          wdata = '{tim: pt_q, amt: pa_q};
        end
        state_d = ret_q;
      end
      S_FD_RD: state_d = single ? S_OUT_RD : S_FD_CHK;
      S_FD_CHK: begin
        if (rd.amt < min_q || qfull) begin
          ha_d    = rd.amt;
          hd_d    = hd_nxt;
          state_d = S_FD_MRD;
        end else begin
          state_d = S_OUT_RD;
        end
      end
      S_FD_MRD: state_d = S_FD_MWR;
      S_FD_MWR: begin
        we      = 1'b1;
        wdata   = '{tim: rd.tim, amt: rd.amt + ha_q};
        state_d = S_FD_RD;
      end
      S_OUT_RD: state_d = S_OUT_WR;
      S_OUT_WR: begin
        if (!out_valid_q || out_ready_i) begin
          out_d = '{head_amount:  rd.amt,
                    head_time:    rd.tim,
                    refill_count: CountW'(qsize),
                    head_ready:   rd.tim <= thr_q};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_valid_i && cfg_ready_o &&
        (cfg_index_i == CFG_REFILL_LIMIT || cfg_index_i == CFG_INIT_BUDGET)) begin
      reload_d = 1'b1;
    end
  end

  always_comb begin
    lim_raw = cfg_data_i[CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      hd_q        <= '0;
      tl_q        <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
      reload_q    <= 1'b1;
      period_q    <= RstPeriod;
      min_q       <= RstMinBudget;
      lim_q       <= LW'(LimRst);
      wcet_q      <= RstWcet;
      init_q      <= RstInitBudget;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      hd_q        <= hd_d;
      tl_q        <= tl_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
      reload_q    <= reload_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_PERIOD:     period_q <= cfg_data_i;
          CFG_MIN_BUDGET: min_q    <= cfg_data_i;
          CFG_REFILL_LIMIT: begin
            if (lim_raw < CountW'(2)) begin
              lim_q <= LW'(2);
            end else if (32'(lim_raw) > 32'(MAX_REFILLS)) begin
              lim_q <= LW'(MAX_REFILLS);
            end else begin
              lim_q <= LW'(lim_raw);
            end
          end
          CFG_KERNEL_WCET: wcet_q <= cfg_data_i;
          CFG_INIT_BUDGET: init_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    usage_q <= usage_d;
    thr_q   <= thr_d;
    pa_q    <= pa_d;
    pt_q    <= pt_d;
    ha_q    <= ha_d;
    ht_q    <= ht_d;
    out_q   <= out_d;
  end

endmodule

>>> hw/rtl/sbrq_div.sv
// Bit-serial divider: remainder of dividend / divisor and quotient * period (mod 2^64).
// Depends on sbrq_pkg.
`timescale 1ns / 1ps

module sbrq_div
  import sbrq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  input  logic [DataW-1:0] period_i,
  output sbrq_div_res_t    res_o
);

  localparam int unsigned CntW = $clog2(DivSteps);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d, dvd_q, dvd_d, acc_q, acc_d, dvs_q, dvs_d, per_q, per_d;
  logic [DataW:0]  trial, diff;
  logic            ge;

  assign trial = {rem_q, dvd_q[DataW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    acc_d  = acc_q;
    dvs_d  = dvs_q;
    per_d  = per_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      acc_d  = '0;
      dvs_d  = divisor_i;
      per_d  = period_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DataW-1:0] : trial[DataW-1:0];
      dvd_d = {dvd_q[DataW-2:0], 1'b0};
      acc_d = {acc_q[DataW-2:0], 1'b0} + (ge ? per_q : '0);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    acc_q <= acc_d;
    dvs_q <= dvs_d;
    per_q <= per_d;
  end

  assign res_o = '{done: done_q, rem: rem_q, acc: acc_q};

endmodule

>>> hw/rtl/sbrq_mem.sv
// Refill store: one write port, one registered read port, {time, amount} per slot.
// Depends on sbrq_pkg.
`timescale 1ns / 1ps

module sbrq_mem
  import sbrq_pkg::*;
#(
  parameter int unsigned Depth = DefMaxRefills,
  parameter int unsigned AddrW = $clog2(DefMaxRefills)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  sbrq_word_t       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output sbrq_word_t       rdata_o
);

  sbrq_word_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/sbrq_chk.sv
// Port-level checker for the refill queue, bound to the top level.
// Depends on sbrq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbrq_chk
  import sbrq_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input sbrq_in_t           in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sbrq_out_t          out_data_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [DataW-1:0]   cfg_data_i
);

  // A stalled result beat stays put.
  `SBRQ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  `SBRQ_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o))
  // The queue never reports itself empty.
  `SBRQ_ASSERT(a_count_nonzero, out_valid_o |-> out_data_o.refill_count != '0)
  // One item at a time: after an accepted beat the input side closes.
  `SBRQ_ASSERT(a_one_in_flight, in_valid_i && in_ready_o |=> !in_ready_o)

endmodule

bind sporadic_budget_refill_queue sbrq_chk u_sbrq_chk (.*);

>>> tb/sv/tb_top.sv
// Testbench for sporadic_budget_refill_queue: directed and random charges checked beat by
// beat against a behavioral refill queue predictor. Depends on sbrq_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_top;
  import sbrq_pkg::*;

  localparam int unsigned NREF = 16;
  localparam int unsigned CYCLE_LIMIT = 5000000;
  localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sbrq_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sbrq_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;

  sporadic_budget_refill_queue uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0] q_amt [NREF];
  logic [63:0] q_tim [NREF];
  int unsigned q_head, q_tail;
  logic [63:0] c_period, c_min, c_wcet, c_init;
  logic [4:0] c_limit;

  sbrq_out_t head_q[$];
  int unsigned n_items, n_checked, n_errors, cyc;
  logic [63:0] now_t;

  function automatic int unsigned lim_f();
    if (c_limit < 2) return 2;
    if (c_limit > NREF) return NREF;
    return c_limit;
  endfunction

  function automatic int unsigned nxt(int unsigned i);
    return (i + 1 >= lim_f()) ? 0 : i + 1;
  endfunction

  function automatic int unsigned qsize();
    if (q_head <= q_tail) return q_tail - q_head + 1;
    return q_tail + 1 + (lim_f() - q_head);
  endfunction

  function automatic void load_single();
    q_head = 0;
    q_tail = 0;
    q_amt[0] = c_init;
    q_tim[0] = '0;
  endfunction

  function automatic void put_used(logic [63:0] a, logic [63:0] t);
    if (a < c_min && q_head != q_tail) begin
      q_amt[q_tail] += a;
      if (t > q_tim[q_tail]) q_tim[q_tail] = t;
    end else if (t <= q_tim[q_tail]) begin
      q_amt[q_tail] += a;
    end else begin
      q_tail = nxt(q_tail);
      q_amt[q_tail] = a;
      q_tim[q_tail] = t;
    end
  endfunction

  function automatic sbrq_out_t charge(sbrq_in_t d);
    logic [63:0] usage, a, k, t, pa, pt, rem, na, nt, horizon;
    int unsigned steps, h;
    sbrq_out_t r;
    usage = d.usage;
    horizon = d.now + c_wcet;
    if (d.capacity == 0) begin
      steps = 0;
      while (q_amt[q_head] <= usage) begin
        a = q_amt[q_head];
        if (q_head == q_tail) begin
          if (a == 0) q_tim[q_head] += c_period;
          else begin
            k = usage / a;
            q_tim[q_head] += k * c_period;
            usage -= k * a;
          end
          break;
        end
        if (steps >= 2 * NREF) break;
        steps++;
        usage -= a;
        t = q_tim[q_head] + c_period;
        q_head = nxt(q_head);
        put_used(a, t);
      end
      if (usage > 0) begin
        q_tim[q_head] += usage;
        if (q_head != q_tail) begin
          t = q_tim[q_head] + q_amt[q_head];
          if (t >= q_tim[nxt(q_head)]) begin
            pa = q_amt[q_head];
            pt = q_tim[q_head];
            q_head = nxt(q_head);
            q_amt[q_head] += pa;
            q_tim[q_head] = pt;
          end
        end
      end
    end
    h = q_head;
    if (q_amt[h] > usage && q_tim[h] <= horizon) begin
      rem = q_amt[h] - usage;
      na = usage;
      nt = q_tim[h] + c_period;
      if (qsize() == lim_f() || rem < c_min) begin
        if (q_head == q_tail) begin
          q_amt[h] = na + rem;
          q_tim[h] = nt;
        end else begin
          q_head = nxt(q_head);
          q_amt[q_head] += rem;
          put_used(na, nt);
        end
      end else begin
        q_amt[h] = rem;
        q_tim[h] += usage;
        put_used(na, nt);
      end
    end
    while (q_head != q_tail && (q_amt[q_head] < c_min || qsize() == lim_f())) begin
      a = q_amt[q_head];
      q_head = nxt(q_head);
      q_amt[q_head] += a;
    end
    r.head_amount = q_amt[q_head];
    r.head_time = q_tim[q_head];
    r.refill_count = 5'(qsize());
    r.head_ready = (q_tim[q_head] <= horizon);
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stalls
  int unsigned stall_left;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      stall_left = gap_len();
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sbrq_out_t e;
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (head_q.size() == 0) begin
        $error("unexpected result beat");
        n_errors++;
      end else begin
        e = head_q.pop_front();
        n_checked++;
        if (out_data_o.head_amount !== e.head_amount) begin
          $error("head_amount exp %0d got %0d", e.head_amount, out_data_o.head_amount);
          n_errors++;
        end
        if (out_data_o.head_time !== e.head_time) begin
          $error("head_time exp %0d got %0d", e.head_time, out_data_o.head_time);
          n_errors++;
        end
        if (out_data_o.refill_count !== e.refill_count) begin
          $error("refill_count exp %0d got %0d", e.refill_count, out_data_o.refill_count);
          n_errors++;
        end
        if (out_data_o.head_ready !== e.head_ready) begin
          $error("head_ready exp %0d got %0d", e.head_ready, out_data_o.head_ready);
          n_errors++;
        end
      end
    end
  end

  task automatic send_charge(logic [63:0] usage, logic [63:0] capacity, logic [63:0] now);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= '{usage: usage, capacity: capacity, now: now};
    do @(posedge clk_i); while (!in_ready_o);
    head_q.push_back(charge(in_data_i));
    n_items++;
  endtask

  task automatic write_reg(sbrq_cfg_e idx, logic [63:0] val);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (head_q.size() == 0);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PERIOD: c_period = val;
      CFG_MIN_BUDGET: c_min = val;
      CFG_REFILL_LIMIT: begin
        c_limit = val[4:0];
        load_single();
      end
      CFG_KERNEL_WCET: c_wcet = val;
      CFG_INIT_BUDGET: begin
        c_init = val;
        load_single();
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_charge(0, 0, 0);
    send_charge(3000, 5, 0);
    send_charge(2000, 5, 100);
    send_charge(9999, 1, 20000);
    send_charge(10000, 0, 20000);
    send_charge(500, 0, 30000);
    send_charge(ALL1, 0, ALL1);
    send_charge(ALL1, ALL1, ALL1);
    send_charge(0, ALL1, 0);
    send_charge(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_charge(64'hAAAA_AAAA_AAAA_AAAA, 0, 64'hAAAA_AAAA_AAAA_AAAA);
    write_reg(CFG_INIT_BUDGET, 0);
    send_charge(0, 0, 0);
    send_charge(7, 0, 5);
    write_reg(CFG_KERNEL_WCET, ALL1);
    write_reg(CFG_INIT_BUDGET, 100);
    for (int i = 0; i < 8; i++) begin
      send_charge(64'(10 + i), (i % 3 == 0) ? 64'd0 : 64'd50, 64'(i * 7));
    end
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_PERIOD, 1);
    write_reg(CFG_MIN_BUDGET, 0);
    write_reg(CFG_KERNEL_WCET, 0);
    write_reg(CFG_REFILL_LIMIT, 2);
    write_reg(CFG_INIT_BUDGET, ALL1);
    for (int i = 0; i < 6; i++) begin
      send_charge(64'($urandom_range(0, 50)), 64'(i % 2), 64'(i * 3));
    end
    write_reg(CFG_PERIOD, ALL1);
    write_reg(CFG_MIN_BUDGET, ALL1);
    write_reg(CFG_REFILL_LIMIT, 31);
    for (int i = 0; i < 6; i++) begin
      send_charge(64'($urandom_range(0, 50)), 64'(i % 2), ALL1 - 64'(i));
    end
    write_reg(CFG_REFILL_LIMIT, 0);
    write_reg(CFG_MIN_BUDGET, 2);
    write_reg(CFG_PERIOD, 10);
    for (int i = 0; i < 6; i++) send_charge(64'(i * 7), 64'(i % 2), 64'(i * 5));
  endtask

  task automatic test_random_phases(int unsigned n_total);
    logic [63:0] p, b, u, c, w;
    int unsigned per_phase, done;
    done = 0;
    now_t = 0;
    while (done < n_total) begin
      p = 64'($urandom_range(1, 1000));
      b = 64'($urandom_range(1, 2000));
      write_reg(CFG_PERIOD, p);
      write_reg(CFG_MIN_BUDGET, 64'($urandom_range(0, 32'(b) / 4)));
      write_reg(CFG_KERNEL_WCET, 64'($urandom_range(0, 50)));
      write_reg(CFG_REFILL_LIMIT, 64'($urandom_range(2, 16)));
      write_reg(CFG_INIT_BUDGET, b);
      now_t = 0;
      per_phase = $urandom_range(40, 160);
      for (int i = 0; i < per_phase && done < n_total; i++) begin
        if ($urandom_range(0, 99) < 8) begin
          u = {$urandom, $urandom};
          c = ($urandom_range(0, 1) != 0) ? 64'd0 : {$urandom, $urandom};
          w = {$urandom, $urandom};
          send_charge(u, c, w);
        end else begin
          now_t += 64'($urandom_range(0, 32'(p)));
          u = 64'($urandom_range(0, 32'(b) * 2));
          c = ($urandom_range(0, 99) < 40) ? 64'd0 : 64'($urandom_range(1, 32'(b)));
          send_charge(u, c, now_t);
        end
        done++;
      end
    end
  endtask

  initial begin
    c_period = RstPeriod;
    c_min = RstMinBudget;
    c_limit = RstLimit;
    c_wcet = RstWcet;
    c_init = RstInitBudget;
    for (int i = 0; i < NREF; i++) begin
      q_amt[i] = '0;
      q_tim[i] = '0;
    end
    load_single();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_extremes();
    test_random_phases(1900);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (head_q.size() == 0);
    repeat (300) @(posedge clk_i);
    $display("Charges sent: %0d, result beats checked: %0d, mismatches: %0d",
             n_items, n_checked, n_errors);
    $display("Covered register extremes, exhaustion, overrun, split and fold paths.");
    if (n_errors == 0 && head_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/sbrq_pkg.sv
hw/rtl/sbrq_div.sv
hw/rtl/sbrq_mem.sv
hw/rtl/sporadic_budget_refill_queue.sv
hw/rtl/sbrq_chk.sv
tb/sv/tb_top.sv
